// ===== rtl/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// shared constants and types for the circle pencil separability test
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [1:0] {
        REG_A_X = 2'd0,
        REG_A_Y = 2'd1,
        REG_B_X = 2'd2,
        REG_B_Y = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW,
        ST_UPDATE,
        ST_HIGH,
        ST_EMIT
    } t_back_state;

endpackage

// ===== rtl/cps_front.sv =====
// ----------------------------------------------------------------------------
// cps_front
// computes alpha and beta for each point and queues the constraint terms
// ----------------------------------------------------------------------------
module cps_front #(
    parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF,
    parameter int NB         = 2 * COORD_BITS + 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic                         i_fence,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [NB-1:0]         o_num,
    output logic signed [NB-1:0]         o_den,
    output logic                         o_bzero,
    output logic                         o_zfail,
    output logic                         o_bpos,
    output logic                         o_fence,
    output logic                         o_last
);
    import cps_pkg::*;

    localparam int DW = COORD_BITS + 3;
    localparam int PW = 2 * DW;

    // stage 1: differences
    logic                 r_s1v;
    logic signed [DW-1:0] r_ux, r_uy, r_dx, r_dy, r_nx, r_ny, r_qx, r_qy;
    logic                 r_s1f, r_s1l;
    logic                 s1_adv;

    // stage 2: products
    logic                 r_s2v;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic                 r_s2f, r_s2l;
    logic                 s2_adv;

    // output queue, two entries
    logic [1:0]           r_cnt;
    logic                 r_wp, r_rp;
    logic signed [NB-1:0] r_qnum [2];
    logic signed [NB-1:0] r_qden [2];
    logic [4:0]           r_qflg [2];

    logic signed [NB-1:0] alpha, beta, num, den;
    logic                 bpos, bzero, zfail;
    logic                 push, pop;

    assign pop    = o_valid && i_ready;
    assign push   = r_s2v && (r_cnt != 2'd2);
    assign s2_adv = !r_s2v || push;
    assign s1_adv = !r_s1v || s2_adv;
    assign o_ready = s1_adv;

    always_comb begin
        alpha = NB'(r_p0) + NB'(r_p1) - NB'(r_p2) - NB'(r_p3);
        beta  = -(NB'(r_p4) + NB'(r_p5)) <<< 1;
        bpos  = (beta > 0);
        bzero = (beta == '0);
        zfail = r_s2f ? (alpha <= 0) : (alpha > 0);
        num   = bpos ? -alpha : alpha;
        den   = bpos ? (beta <<< 2) : -(beta <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (s1_adv) r_s1v <= i_valid;
            if (s2_adv) r_s2v <= r_s1v;
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_ux  <= (DW'(i_px) <<< 1) - DW'(i_ax) - DW'(i_bx);
            r_uy  <= (DW'(i_py) <<< 1) - DW'(i_ay) - DW'(i_by);
            r_dx  <= DW'(i_ax) - DW'(i_bx);
            r_dy  <= DW'(i_ay) - DW'(i_by);
            r_nx  <= DW'(i_ay) - DW'(i_by);
            r_ny  <= DW'(i_bx) - DW'(i_ax);
            r_qx  <= DW'(i_px) - DW'(i_ax);
            r_qy  <= DW'(i_py) - DW'(i_ay);
            r_s1f <= i_fence;
            r_s1l <= i_last;
        end
        if (s2_adv) begin
            r_p0  <= PW'(r_ux) * PW'(r_ux);
            r_p1  <= PW'(r_uy) * PW'(r_uy);
            r_p2  <= PW'(r_dx) * PW'(r_dx);
            r_p3  <= PW'(r_dy) * PW'(r_dy);
            r_p4  <= PW'(r_nx) * PW'(r_qx);
            r_p5  <= PW'(r_ny) * PW'(r_qy);
            r_s2f <= r_s1f;
            r_s2l <= r_s1l;
        end
        if (push) begin
            r_qnum[r_wp] <= num;
            r_qden[r_wp] <= den;
            r_qflg[r_wp] <= {bzero, zfail, bpos, r_s2f, r_s2l};
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_num   = r_qnum[r_rp];
    assign o_den   = r_qden[r_rp];
    assign o_bzero = r_qflg[r_rp][4];
    assign o_zfail = r_qflg[r_rp][3];
    assign o_bpos  = r_qflg[r_rp][2];
    assign o_fence = r_qflg[r_rp][1];
    assign o_last  = r_qflg[r_rp][0];

endmodule

// ===== rtl/cps_back.sv =====
// ----------------------------------------------------------------------------
// cps_back
// tightens rational bounds and reports feasibility on the last point
// ----------------------------------------------------------------------------
module cps_back #(
    parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF,
    parameter int NB         = 2 * COORD_BITS + 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [NB-1:0] i_num,
    input  logic signed [NB-1:0] i_den,
    input  logic                 i_bzero,
    input  logic                 i_zfail,
    input  logic                 i_bpos,
    input  logic                 i_fence,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_accepted
);
    import cps_pkg::*;

    localparam int MW = 2 * NB;

    t_back_state          r_state, n_state;
    logic signed [NB-1:0] r_lnum, r_lden, r_hnum, r_hden;
    logic                 r_lv, r_ls, r_hv, r_hs, r_rej;
    logic signed [NB-1:0] r_num, r_den;
    logic                 r_isl, r_str, r_lst;
    logic signed [MW-1:0] r_m1, r_m2;
    logic                 r_ov, r_acc;

    logic                 take, to_low, emit_go;
    logic signed [NB-1:0] an, ad, bn, bd;
    logic                 cmp_lt, cmp_eq, hit_lt, hit_eq;
    logic                 feasible;

    assign to_low  = i_fence ? i_bpos : !i_bpos;
    assign take    = i_valid && (r_state == ST_IDLE);
    assign o_ready = (r_state == ST_IDLE);
    assign emit_go = (r_state == ST_EMIT) && (!r_ov || i_ready);

    // selects operands for the registered cross products, then compares them
    always_comb begin
        an = r_lnum; ad = r_lden; bn = r_num; bd = r_den;
        if (r_state == ST_HIGH || r_state == ST_EMIT) begin
            an = r_hnum; ad = r_hden; bn = r_lnum; bd = r_lden;
        end else if (!r_isl) begin
            an = r_num; ad = r_den; bn = r_hnum; bd = r_hden;
        end
        cmp_lt = (r_m1 < r_m2);
        cmp_eq = (r_m1 == r_m2);
    end

    always_comb begin
        hit_lt = cmp_lt;
        hit_eq = cmp_eq;
        feasible = !r_rej && (!r_lv || !r_hv || !cmp_lt && (!cmp_eq || (!r_ls && !r_hs)));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_LOW;
            ST_LOW:    n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_lst ? ST_HIGH : ST_IDLE;
            ST_HIGH:   n_state = ST_EMIT;
            ST_EMIT:   if (emit_go) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lnum <= '0; r_lden <= NB'(1); r_lv <= 1'b0; r_ls <= 1'b0;
            r_hnum <= '0; r_hden <= NB'(1); r_hv <= 1'b0; r_hs <= 1'b0;
            r_rej  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_go) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (take && !i_bzero) begin
                r_num <= i_num; r_den <= i_den;
                r_isl <= to_low; r_str <= i_fence;
            end
            if (take) begin
                r_lst <= i_last;
                if (i_bzero && i_zfail) r_rej <= 1'b1;
                if (i_bzero) r_isl <= 1'b0;
                if (i_bzero) r_den <= '0;
            end
            if (r_state == ST_UPDATE && r_den != '0) begin
                if (r_isl) begin
                    if (!r_lv || hit_lt) begin
                        r_lnum <= r_num; r_lden <= r_den; r_lv <= 1'b1; r_ls <= r_str;
                    end else if (hit_eq) r_ls <= r_ls | r_str;
                end else begin
                    if (!r_hv || hit_lt) begin
                        r_hnum <= r_num; r_hden <= r_den; r_hv <= 1'b1; r_hs <= r_str;
                    end else if (hit_eq) r_hs <= r_hs | r_str;
                end
            end
            if (emit_go) begin
                r_acc  <= feasible;
                r_lnum <= '0; r_lden <= NB'(1); r_lv <= 1'b0; r_ls <= 1'b0;
                r_hnum <= '0; r_hden <= NB'(1); r_hv <= 1'b0; r_hs <= 1'b0;
                r_rej  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= MW'(an) * MW'(bd);
        r_m2 <= MW'(bn) * MW'(ad);
    end

    assign o_valid    = r_ov;
    assign o_accepted = r_acc;

endmodule

// ===== rtl/circle_pencil_separability_test.sv =====
// ----------------------------------------------------------------------------
// circle_pencil_separability_test
// a last point passes front stages 1 and 2 and the output queue, then back states
// LOW, UPDATE, HIGH and EMIT before result valid, later when the back is still busy
// or the result output is stalled; the back takes a new point only from IDLE
// synchronous active-low reset clears bounds, anchors to A=(0,0) B=(1,0)
// ----------------------------------------------------------------------------
module circle_pencil_separability_test #(
    parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x, point_y, then zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted, then zero fill
    output logic [7:0]                          m_axis_tdata
);
    import cps_pkg::*;

    localparam int NB = 2 * COORD_BITS + 6;

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic                 q_valid, q_ready, q_bzero, q_zfail, q_bpos, q_fence, q_last;
    logic signed [NB-1:0] q_num, q_den;
    logic                 acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= COORD_BITS'(1);
            r_by <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_A_X: r_ax <= i_cfg_data;
                REG_A_Y: r_ay <= i_cfg_data;
                REG_B_X: r_bx <= i_cfg_data;
                REG_B_Y: r_by <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cps_front #(.COORD_BITS(COORD_BITS), .NB(NB)) u_front (
        .i_clk, .i_rst_n,
        .i_ax(r_ax), .i_ay(r_ay), .i_bx(r_bx), .i_by(r_by),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_px(s_axis_tdata[COORD_BITS-1:0]),
        .i_py(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_fence(s_axis_tuser), .i_last(s_axis_tlast),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_num(q_num), .o_den(q_den), .o_bzero(q_bzero), .o_zfail(q_zfail),
        .o_bpos(q_bpos), .o_fence(q_fence), .o_last(q_last)
    );

    cps_back #(.COORD_BITS(COORD_BITS), .NB(NB)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_num(q_num), .i_den(q_den), .i_bzero(q_bzero), .i_zfail(q_zfail),
        .i_bpos(q_bpos), .i_fence(q_fence), .i_last(q_last),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_accepted(acc)
    );

    assign m_axis_tdata = {7'd0, acc};

endmodule
